// ===== sv/touch_baseline_hysteresis_detector_core_defines.svh =====
// Assertion macros for the touch baseline hysteresis detector.
// Included by the top level; depends on nothing else.
`ifndef TOUCH_BASELINE_HYSTERESIS_DETECTOR_CORE_DEFINES_SVH
`define TOUCH_BASELINE_HYSTERESIS_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TBHD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TBHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tbhd_pkg.sv =====
// Shared constants, codes and types of the touch baseline hysteresis detector.
// Used by the channel interfaces, the register block, the tracker and the top level.
package tbhd_pkg;

    localparam int CHANNELS    = 12;
    localparam int SAMPLE_BITS = 10;
    localparam int FRAC_BITS   = 8;

    localparam int BASE_W   = SAMPLE_BITS + FRAC_BITS;
    localparam int DELTA_W  = BASE_W + 1;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Fixed field widths of the ports
    localparam int CH_W        = 4;
    localparam int SAMPLE_W    = 10;
    localparam int EVENT_W     = 2;
    localparam int OUT_DELTA_W = 19;
    localparam int TH_W        = 18;
    localparam int RATE_REG_W  = 14;

    // Adaptation rate in units of 1/65536
    localparam int RATE_SHIFT = 16;
    localparam int RATE_W     = RATE_SHIFT + 1;
    localparam int RATE_ONE   = 1 << RATE_SHIFT;
    localparam int RATE_MIN   = 7;
    localparam int RATE_MAX   = 13107;

    // APB register map
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;
    localparam logic [REG_IDX_W-1:0] REG_TOUCH_THR   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE_THR = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BASE_RATE   = 2'd2;

    localparam logic [TH_W-1:0]       TOUCH_THR_RST   = 18'd2048;
    localparam logic [TH_W-1:0]       RELEASE_THR_RST = 18'd1024;
    localparam logic [RATE_REG_W-1:0] BASE_RATE_RST   = 14'd655;

    // Result event codes
    localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EVENT_W-1:0] EV_TOUCH   = 2'd1;
    localparam logic [EVENT_W-1:0] EV_RELEASE = 2'd2;

    // Effective settings handed from the register block to the datapath
    typedef struct packed {
        logic [TH_W-1:0]   touch_thr;
        logic [TH_W-1:0]   release_thr;
        logic [RATE_W-1:0] rate;
        logic [RATE_W-1:0] rate_fast;
    } cfg_t;

endpackage

// ===== sv/tbhd_if.sv =====
// Valid/ready channel interfaces for samples in and results out.
// Depends on tbhd_pkg for the field widths.
interface tbhd_in_if;
    logic                          valid;
    logic                          ready;
    logic [tbhd_pkg::CH_W-1:0]     channel;
    logic [tbhd_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface tbhd_out_if;
    logic                                    valid;
    logic                                    ready;
    logic [tbhd_pkg::CH_W-1:0]               out_channel;
    logic                                    touched;
    logic [tbhd_pkg::EVENT_W-1:0]            event_res;
    logic signed [tbhd_pkg::OUT_DELTA_W-1:0] delta;

    modport source (output valid, output out_channel, output touched, output event_res,
                    output delta, input ready);
    modport sink   (input valid, input out_channel, input touched, input event_res,
                    input delta, output ready);
endinterface

// ===== sv/tbhd_cfg_regs.sv =====
// APB register block: thresholds and base rate, plus the derived effective settings.
// Depends on tbhd_pkg.
module tbhd_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tbhd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tbhd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tbhd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output tbhd_pkg::cfg_t                  cfg
);

    logic [tbhd_pkg::TH_W-1:0]       touch_thr_reg;
    logic [tbhd_pkg::TH_W-1:0]       release_thr_reg;
    logic [tbhd_pkg::RATE_REG_W-1:0] base_rate_reg;
    logic [tbhd_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                            wr_en;
    logic [tbhd_pkg::RATE_W-1:0]     rate_clamped;
    logic [tbhd_pkg::RATE_W+2:0]     rate_x5;

    assign pready  = 1'b1;
    assign reg_idx = paddr[tbhd_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_thr_reg   <= tbhd_pkg::TOUCH_THR_RST;
            release_thr_reg <= tbhd_pkg::RELEASE_THR_RST;
            base_rate_reg   <= tbhd_pkg::BASE_RATE_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                tbhd_pkg::REG_TOUCH_THR:   touch_thr_reg   <= pwdata[tbhd_pkg::TH_W-1:0];
                tbhd_pkg::REG_RELEASE_THR: release_thr_reg <= pwdata[tbhd_pkg::TH_W-1:0];
                tbhd_pkg::REG_BASE_RATE:   base_rate_reg   <= pwdata[tbhd_pkg::RATE_REG_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            tbhd_pkg::REG_TOUCH_THR:   prdata = tbhd_pkg::APB_DATA_W'(touch_thr_reg);
            tbhd_pkg::REG_RELEASE_THR: prdata = tbhd_pkg::APB_DATA_W'(release_thr_reg);
            tbhd_pkg::REG_BASE_RATE:   prdata = tbhd_pkg::APB_DATA_W'(base_rate_reg);
            default:                   prdata = '0;
        endcase
    end

    // Clamp the rate, fall back to half the touch threshold when the release
    // threshold gives no hysteresis, and saturate the fast release rate.
    always_comb
    begin
        if (32'(base_rate_reg) < 32'(tbhd_pkg::RATE_MIN))
            rate_clamped = tbhd_pkg::RATE_W'(tbhd_pkg::RATE_MIN);
        else if (32'(base_rate_reg) > 32'(tbhd_pkg::RATE_MAX))
            rate_clamped = tbhd_pkg::RATE_W'(tbhd_pkg::RATE_MAX);
        else
            rate_clamped = tbhd_pkg::RATE_W'(base_rate_reg);

        rate_x5 = {rate_clamped, 2'b00} + (tbhd_pkg::RATE_W+3)'(rate_clamped);

        cfg.touch_thr = touch_thr_reg;
        cfg.release_thr = (release_thr_reg >= touch_thr_reg) ? (touch_thr_reg >> 1)
                                                             : release_thr_reg;
        cfg.rate = rate_clamped;
        if (32'(rate_x5) > 32'(tbhd_pkg::RATE_ONE))
            cfg.rate_fast = tbhd_pkg::RATE_W'(tbhd_pkg::RATE_ONE);
        else
            cfg.rate_fast = tbhd_pkg::RATE_W'(rate_x5);
    end

endmodule

// ===== sv/tbhd_track.sv =====
// Baseline tracker: moves a baseline toward a target by rate/65536, rounded half up.
// Depends on tbhd_pkg.
module tbhd_track
(
    input  logic [tbhd_pkg::BASE_W-1:0] base,
    input  logic [tbhd_pkg::BASE_W-1:0] target,
    input  logic [tbhd_pkg::RATE_W-1:0] rate,
    output logic [tbhd_pkg::BASE_W-1:0] base_new
);

    localparam int PROD_W = tbhd_pkg::BASE_W + tbhd_pkg::RATE_W + 2;
    localparam int SUM_W  = tbhd_pkg::BASE_W + 2;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1 << (tbhd_pkg::RATE_SHIFT - 1));

    logic signed [tbhd_pkg::BASE_W:0] diff;
    logic signed [tbhd_pkg::RATE_W:0] rate_s;
    logic signed [PROD_W-1:0]         prod;
    logic signed [PROD_W-1:0]         step;
    logic signed [SUM_W-1:0]          sum;

    always_comb
    begin
        diff   = $signed({1'b0, target}) - $signed({1'b0, base});
        rate_s = $signed({1'b0, rate});
        prod   = PROD_W'(diff) * PROD_W'(rate_s);
        step   = (prod + HALF) >>> tbhd_pkg::RATE_SHIFT;
        // step never overshoots diff, so it fits the sum width
        sum    = SUM_W'($signed({1'b0, base})) + SUM_W'(step);
        if (sum < 0)
            base_new = '0;
        else
            base_new = sum[tbhd_pkg::BASE_W-1:0];
    end

endmodule

// ===== sv/touch_baseline_hysteresis_detector_core.sv =====
// Touch detector core: per-channel baseline tracking with touch/release hysteresis.
// Path: a sample transfer passes the input register, then the result register. One sample
// per cycle unless results.ready stalls; the per-channel update with one multiplier fits
// between the two registers, and channel state is written back at the result edge.
// Reset: control state and touch/seeded flags clear, registers load their defaults;
// baselines hold no value until the first sample on a channel seeds them.
`include "touch_baseline_hysteresis_detector_core_defines.svh"

module touch_baseline_hysteresis_detector_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tbhd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tbhd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tbhd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    tbhd_in_if.sink                         samples,
    tbhd_out_if.source                      results
);

    localparam int CMP_W = tbhd_pkg::DELTA_W + 2;

    tbhd_pkg::cfg_t cfg;

    // Input register
    logic                            in_valid_reg;
    logic [tbhd_pkg::CH_W-1:0]       in_ch_reg;
    logic [tbhd_pkg::SAMPLE_W-1:0]   in_sample_reg;

    // Per-channel state
    logic [tbhd_pkg::CHANNELS-1:0]   touch_reg;
    logic [tbhd_pkg::CHANNELS-1:0]   seeded_reg;
    logic [tbhd_pkg::BASE_W-1:0]     base_reg [tbhd_pkg::CHANNELS];

    // Result register
    logic                            out_valid_reg;
    logic [tbhd_pkg::CH_W-1:0]       out_ch_reg;
    logic                            touched_reg;
    logic [tbhd_pkg::EVENT_W-1:0]    event_reg;
    logic signed [tbhd_pkg::OUT_DELTA_W-1:0] delta_reg;

    logic                                advance;
    logic                                in_range;
    logic [tbhd_pkg::CH_IDX_W-1:0]       idx;
    logic [tbhd_pkg::SAMPLE_BITS-1:0]    sample_low;
    logic [tbhd_pkg::BASE_W-1:0]         sample_fix;
    logic [tbhd_pkg::BASE_W-1:0]         base_cur;
    logic                                seeded_cur;
    logic                                touch_cur;
    logic signed [tbhd_pkg::DELTA_W-1:0] d;
    logic                                hit_touch;
    logic                                hit_release;
    logic [tbhd_pkg::RATE_W-1:0]         rate_sel;
    logic [tbhd_pkg::BASE_W-1:0]         tracked;

    logic                                base_we;
    logic [tbhd_pkg::BASE_W-1:0]         base_next;
    logic                                flags_we;
    logic                                touch_next;
    logic                                touched_next;
    logic [tbhd_pkg::EVENT_W-1:0]        event_next;
    logic signed [tbhd_pkg::DELTA_W-1:0] delta_next;

    tbhd_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Move the held item into the result register when that register is free
    assign advance       = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (samples.ready)
            in_valid_reg <= samples.valid;
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            in_ch_reg     <= samples.channel;
            in_sample_reg <= samples.sample;
        end
    end

    assign in_range   = 32'(in_ch_reg) < 32'(tbhd_pkg::CHANNELS);
    assign idx        = tbhd_pkg::CH_IDX_W'(in_ch_reg);
    assign sample_low = tbhd_pkg::SAMPLE_BITS'(in_sample_reg);
    assign sample_fix = {sample_low, {tbhd_pkg::FRAC_BITS{1'b0}}};
    assign base_cur   = base_reg[idx];
    assign seeded_cur = seeded_reg[idx];
    assign touch_cur  = touch_reg[idx];

    assign d           = $signed({1'b0, base_cur}) - $signed({1'b0, sample_fix});
    assign hit_touch   = CMP_W'(d) >= $signed(CMP_W'(cfg.touch_thr));
    assign hit_release = CMP_W'(d) <= $signed(CMP_W'(cfg.release_thr));
    assign rate_sel    = touch_cur ? cfg.rate_fast : cfg.rate;

    tbhd_track u_track
    (
        .base     (base_cur),
        .target   (sample_fix),
        .rate     (rate_sel),
        .base_new (tracked)
    );

    always_comb
    begin
        base_we      = 1'b0;
        base_next    = tracked;
        flags_we     = 1'b0;
        touch_next   = touch_cur;
        touched_next = 1'b0;
        event_next   = tbhd_pkg::EV_NONE;
        delta_next   = '0;
        if (in_range)
        begin
            flags_we = 1'b1;
            if (!seeded_cur)
            begin
                // First sample seeds the baseline; no touch test
                base_we    = 1'b1;
                base_next  = sample_fix;
                touch_next = 1'b0;
            end
            else
            begin
                delta_next = d;
                if (!touch_cur)
                begin
                    if (hit_touch)
                    begin
                        touch_next = 1'b1;
                        event_next = tbhd_pkg::EV_TOUCH;
                    end
                    else
                        base_we = 1'b1;
                end
                else if (hit_release)
                begin
                    touch_next = 1'b0;
                    event_next = tbhd_pkg::EV_RELEASE;
                    base_we    = 1'b1;
                end
                touched_next = touch_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_reg  <= '0;
            seeded_reg <= '0;
        end
        else if (advance && flags_we)
        begin
            touch_reg[idx]  <= touch_next;
            seeded_reg[idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && base_we)
            base_reg[idx] <= base_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_ch_reg  <= in_ch_reg;
            touched_reg <= touched_next;
            event_reg   <= event_next;
            delta_reg   <= tbhd_pkg::OUT_DELTA_W'(delta_next);
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.out_channel = out_ch_reg;
    assign results.touched     = touched_reg;
    assign results.event_res   = event_reg;
    assign results.delta       = delta_reg;

    `TBHD_ASSERT_NOW(a_touch_event_touched, clk, rst_n,
        out_valid_reg && (event_reg == tbhd_pkg::EV_TOUCH), touched_reg,
        "touch event reported without touched state")
    `TBHD_ASSERT_NOW(a_release_event_clear, clk, rst_n,
        out_valid_reg && (event_reg == tbhd_pkg::EV_RELEASE), !touched_reg,
        "release event reported while still touched")
    `TBHD_ASSERT_NEXT(a_touch_flag_follows, clk, rst_n,
        advance && (event_next == tbhd_pkg::EV_TOUCH), touch_reg[$past(idx)],
        "touch event did not set the channel touch flag")
    `TBHD_ASSERT_NEXT(a_stalled_item_held, clk, rst_n,
        in_valid_reg && !advance, in_valid_reg && (in_ch_reg == $past(in_ch_reg)),
        "held sample lost while the result register was full")

endmodule
